// ===== src/gvr_pkg.sv =====
// Package with shared command and status types for the GF(2) rank block.
`timescale 1ns / 1ps

package gvr_pkg;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_INSERT
  } gvr_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;    // capture an accepted item and restart the pivot walk
    logic step;    // reduce against the next pivot
    logic insert;  // insert the remainder, emit the rank on the last item
  } gvr_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic reduce_done;  // every stored pivot has been visited
    logic last_item;    // the item being worked on closes its set
    logic out_free;     // the result register can take a new result
  } gvr_sts_t;

  localparam int unsigned VecFieldBits  = 16;
  localparam int unsigned RankFieldBits = 5;
  localparam int unsigned OutDataBits   = 8;

endpackage

// ===== src/gvr_ctrl.sv =====
// Controller state machine that sequences load, reduction and insertion of one item.
`timescale 1ns / 1ps

module gvr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  gvr_pkg::gvr_sts_t sts,
  output gvr_pkg::gvr_cmd_t cmd
);
  import gvr_pkg::*;

  gvr_state_t state;
  gvr_state_t state_next;

  // Hold the state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Decode next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        // Keep the input closed while reset is applied
        s_tready = !rst;
        if (s_tvalid && !rst) begin
          cmd.load   = 1'b1;
          state_next = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (sts.reduce_done) begin
          state_next = ST_INSERT;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_INSERT: begin
        // Wait here only when a rank must go out and the result slot is taken
        if (!sts.last_item || sts.out_free) begin
          cmd.insert = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== src/gvr_datapath.sv =====
// Datapath: sorted pivot basis, serial reducer, sorted insert and result register.
`timescale 1ns / 1ps

module gvr_datapath #(
  parameter int unsigned VEC_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [gvr_pkg::VecFieldBits-1:0]     vec,
  input  logic                                 last,
  input  gvr_pkg::gvr_cmd_t                    cmd,
  output gvr_pkg::gvr_sts_t                    sts,
  output logic [gvr_pkg::RankFieldBits-1:0]    rank,
  output logic                                 out_valid,
  input  logic                                 out_ready
);
  import gvr_pkg::*;

  localparam int unsigned CW = $clog2(VEC_BITS + 1);
  localparam int unsigned IW = $clog2(VEC_BITS);

  logic [VEC_BITS-1:0] pivots [VEC_BITS];
  logic [VEC_BITS-1:0] pivots_next [VEC_BITS];
  logic [CW-1:0]       count;
  logic [CW-1:0]       walk;
  logic [VEC_BITS-1:0] x;
  logic                last_flag;

  logic [VEC_BITS+VecFieldBits-1:0] vec_ext;
  logic [VEC_BITS-1:0] vec_in;
  logic [VEC_BITS-1:0] cur_pivot;
  logic [VEC_BITS-1:0] x_xor;
  logic                do_ins;
  logic [CW-1:0]       count_after;
  logic [CW+RankFieldBits-1:0] rank_ext;
  logic [VEC_BITS-1:0] keep;

  // Keep only the low VEC_BITS coordinates of the item
  assign vec_ext = {{VEC_BITS{1'b0}}, vec};
  assign vec_in  = vec_ext[VEC_BITS-1:0];

  // One reduction step against the pivot at the walk position
  assign cur_pivot = pivots[walk[IW-1:0]];
  assign x_xor     = x ^ cur_pivot;

  // Insert a nonzero remainder while the basis has room
  assign do_ins      = (x != '0) && (count < CW'(VEC_BITS));
  assign count_after = do_ins ? count + CW'(1) : count;
  assign rank_ext    = {{RankFieldBits{1'b0}}, count_after};

  // Shift the entries below the insert point down by one and drop x in
  always_comb begin
    for (int i = 0; i < VEC_BITS; i++) begin
      keep[i] = (CW'(i) < count) && (pivots[i] > x);
    end
    pivots_next[0] = keep[0] ? pivots[0] : x;
    for (int i = 1; i < VEC_BITS; i++) begin
      if (keep[i]) begin
        pivots_next[i] = pivots[i];
      end else if (keep[i-1]) begin
        pivots_next[i] = x;
      end else begin
        pivots_next[i] = pivots[i-1];
      end
    end
  end

  assign sts.reduce_done = (walk == count);
  assign sts.last_item   = last_flag;
  assign sts.out_free    = !out_valid || out_ready;

  // Advance the working vector and walk position
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x         <= vec_in;
      last_flag <= last;
    end else if (cmd.step) begin
      if (x_xor < x) begin
        x <= x_xor;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walk <= '0;
    end else if (cmd.load) begin
      walk <= '0;
    end else if (cmd.step) begin
      walk <= walk + CW'(1);
    end
  end

  // Update the basis; the count drops to zero once a set is closed
  always_ff @(posedge clk) begin
    if (cmd.insert && do_ins) begin
      pivots <= pivots_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.insert) begin
      count <= last_flag ? '0 : count_after;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (cmd.insert && last_flag) begin
      rank <= rank_ext[RankFieldBits-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.insert && last_flag) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== src/gf2_vector_set_rank.sv =====
// Top level of the GF(2) vector set rank block.
//
// Input channel s_*: one item per vector, tdata[15:0] is the vector (bit i is
// coordinate i, bits at and above VEC_BITS are ignored) and tlast marks the
// final vector of a set. Output channel m_*: one item per set, tdata[4:0] is
// the rank of the set over GF(2), masked to five bits.
//
// Each vector is reduced against the stored pivots one per cycle, then the
// remainder is placed at its sorted spot. After an item is taken the input
// stays closed until the item has been reduced against every pivot held
// before it arrived and then inserted, so a new vector is taken only once
// the previous one is through; the serial pivot walk sets this spacing. The
// rank appears on m_tdata in the cycle after the last item's insert.
//
// Reset empties the basis and drops any pending result. The result register
// decouples the two sides: a stalled receiver holds the rank in place while
// new vectors keep being taken; the block only waits when a second set
// closes before the previous rank has been taken.
`timescale 1ns / 1ps

module gf2_vector_set_rank #(
  parameter int unsigned VEC_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [gvr_pkg::VecFieldBits-1:0] s_tdata,   // [15:0] vec
  input  logic                             s_tlast,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [gvr_pkg::OutDataBits-1:0]  m_tdata    // [4:0] rank, [7:5] zero
);
  import gvr_pkg::*;

  gvr_cmd_t                 cmd;
  gvr_sts_t                 sts;
  logic [RankFieldBits-1:0] rank;

  gvr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  gvr_datapath #(
    .VEC_BITS (VEC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .vec       (s_tdata),
    .last      (s_tlast),
    .cmd       (cmd),
    .sts       (sts),
    .rank      (rank),
    .out_valid (m_tvalid),
    .out_ready (m_tready)
  );

  assign m_tdata = {{(OutDataBits - RankFieldBits){1'b0}}, rank};

  // One item at a time: input is closed right after an item is taken
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while an item is in work");

  // A rank only appears at the close of an item's work
  a_rank_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("rank emitted without an item in work");

  // Rank never exceeds the vector width
  a_rank_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (32'(m_tdata[RankFieldBits-1:0]) <= VEC_BITS))
    else $error("rank above vector width");

endmodule
